### design/sro_pkg.sv
// ----------------------------------------------------------------------------
// sro_pkg: shared types and constants for the sequence reorder block
// Holds the item structs, the kind/op codes and the controller command bundle.
// ----------------------------------------------------------------------------
package sro_pkg;
	localparam int WINDOW = 16;
	localparam int IDX_W  = $clog2(WINDOW);

	localparam logic [1:0] OP_DATA = 2'd0;
	localparam logic [1:0] OP_HB   = 2'd1;
	localparam logic [1:0] OP_SHUT = 2'd2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_GAP  = 2'd1;
	localparam logic [1:0] KIND_SHUT = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] seq;
		logic [31:0] payload;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] out_seq;
		logic [31:0] gap_last;
		logic [31:0] out_payload;
		logic        last;
	} out_item_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // capture the input item
		logic set_start;  // expected <= seq when not started
		logic emit_item;  // emit captured data item, expected++
		logic emit_slot;  // emit stash entry at expected, clear it, expected++
		logic emit_gap;   // emit gap up to next stashed item, jump expected
		logic emit_fgap;  // emit gap up to seq-1, expected <= seq
		logic stash;      // stash the captured item
		logic hb_mark;    // heartbeat_mark <= expected
		logic shut_cnt;   // bump shutdown counter
		logic emit_shut;  // emit shutdown and stop
		logic last;       // release the held result as the final one
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic [1:0] op;
		logic       stopped;
		logic       eq;         // seq == expected
		logic       gt;         // seq > expected
		logic       far;        // seq beyond the window
		logic       exp_full;   // slot at expected holds an item
		logic       gap_found;  // a later stashed item exists in window
		logic       hb_idle;    // expected == heartbeat_mark
		logic       shut_hit;   // this shutdown reaches the needed count
	} stat_t;
endpackage

### design/sro_datapath.sv
// ----------------------------------------------------------------------------
// sro_datapath: expected number, stash, counters and the result register
// Executes one controller command per cycle; each result is held until the next
// is formed or the block goes idle, so the final one of a transaction can be flagged.
// ----------------------------------------------------------------------------
module sro_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sro_pkg::in_item_t   item,
	input  logic [7:0]          shut_need,
	input  sro_pkg::cmd_t       cmd,
	output sro_pkg::stat_t      st,
	output sro_pkg::out_item_t  res,
	output logic                res_strobe
);
	import sro_pkg::*;

	in_item_t          cur_q;
	logic [31:0]       exp_q;
	logic [31:0]       hb_q;
	logic [7:0]        scnt_q;
	logic              stop_q;
	logic [WINDOW-1:0] full_q;
	logic [31:0]       word_q [WINDOW];
	out_item_t         pend_q;
	logic              pend_v_q;
	out_item_t         res_q;
	logic              strobe_q;

	logic [IDX_W-1:0]  exp_idx;
	logic [IDX_W-1:0]  cur_idx;
	logic [31:0]       diff;
	logic [7:0]        need;
	logic [7:0]        scnt_nx;
	logic [WINDOW-1:0] rot;
	logic [IDX_W-1:0]  gap_d;
	logic              gap_hit;
	logic              emit_any;
	out_item_t         emit_res;
	out_item_t         fin_res;

	assign exp_idx = exp_q[IDX_W-1:0];
	assign cur_idx = cur_q.seq[IDX_W-1:0];
	assign diff    = cur_q.seq - exp_q;
	assign need    = (shut_need == 8'd0) ? 8'd1 : shut_need;
	assign scnt_nx = scnt_q + 8'd1;

	// rotate full bits so bit d is slot of expected+d; find first d >= 1
	always_comb begin
		rot     = (full_q >> exp_idx) | (full_q << (IDX_W'(WINDOW) - exp_idx));
		gap_d   = '0;
		gap_hit = 1'b0;
		for (int d = WINDOW - 1; d >= 1; d--) begin
			if (rot[d]) begin
				gap_d   = IDX_W'(d);
				gap_hit = 1'b1;
			end
		end
	end

	always_comb begin
		st.op        = cur_q.op;
		st.stopped   = stop_q;
		st.eq        = (cur_q.seq == exp_q);
		st.gt        = (cur_q.seq > exp_q);
		st.far       = (cur_q.seq > exp_q) && (diff >= 32'(WINDOW));
		st.exp_full  = full_q[exp_idx];
		st.gap_found = gap_hit;
		st.hb_idle   = (exp_q == hb_q);
		st.shut_hit  = (scnt_nx == need);
	end

	// result formed this cycle, and the held result flagged as final
	always_comb begin
		emit_any = cmd.emit_item | cmd.emit_slot | cmd.emit_gap | cmd.emit_fgap |
			cmd.emit_shut;
		emit_res = '0;
		if (cmd.emit_item) begin
			emit_res = '{KIND_DATA, cur_q.seq, 32'd0, cur_q.payload, 1'b0};
		end else if (cmd.emit_slot) begin
			emit_res = '{KIND_DATA, exp_q, 32'd0, word_q[exp_idx], 1'b0};
		end else if (cmd.emit_gap) begin
			emit_res = '{KIND_GAP, exp_q, exp_q + 32'(gap_d) - 32'd1, 32'd0, 1'b0};
		end else if (cmd.emit_fgap) begin
			emit_res = '{KIND_GAP, exp_q, cur_q.seq - 32'd1, 32'd0, 1'b0};
		end else if (cmd.emit_shut) begin
			emit_res = '{KIND_SHUT, 32'd0, 32'd0, 32'd0, 1'b0};
		end
		fin_res      = pend_q;
		fin_res.last = 1'b1;
	end

	// stash payload words
	always_ff @(posedge clk) begin
		if (cmd.stash && !full_q[cur_idx]) begin
			word_q[cur_idx] <= cur_q.payload;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= item;
		end
	end

	// control state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q    <= '0;
			hb_q     <= '0;
			scnt_q   <= '0;
			stop_q   <= 1'b0;
			full_q   <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
			res_q    <= '0;
		end else begin
			// a new result pushes the held one out; going idle flags it final
			strobe_q <= pend_v_q && (emit_any || cmd.last);
			if (pend_v_q && (emit_any || cmd.last)) begin
				res_q <= emit_any ? pend_q : fin_res;
			end
			if (emit_any) begin
				pend_q   <= emit_res;
				pend_v_q <= 1'b1;
			end else if (cmd.last) begin
				pend_v_q <= 1'b0;
			end
			// expected number
			if (cmd.set_start && exp_q == 32'd0) begin
				exp_q <= cur_q.seq;
			end else if (cmd.emit_item || cmd.emit_slot) begin
				exp_q <= exp_q + 32'd1;
			end else if (cmd.emit_gap) begin
				exp_q <= exp_q + 32'(gap_d);
			end else if (cmd.emit_fgap) begin
				exp_q <= cur_q.seq;
			end
			// stash valid bits
			if (cmd.emit_slot) begin
				full_q[exp_idx] <= 1'b0;
			end else if (cmd.stash) begin
				full_q[cur_idx] <= 1'b1;
			end
			if (cmd.hb_mark) begin
				hb_q <= exp_q;
			end
			if (cmd.shut_cnt) begin
				scnt_q <= scnt_nx;
			end
			if (cmd.emit_shut) begin
				stop_q <= 1'b1;
			end
		end
	end

	assign res        = res_q;
	assign res_strobe = strobe_q;
endmodule

### design/sro_ctrl.sv
// ----------------------------------------------------------------------------
// sro_ctrl: sequencing state machine for the reorder block
// Walks one input transaction through start, gap release, emit and drain.
// ----------------------------------------------------------------------------
module sro_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  sro_pkg::stat_t st,
	output logic           busy,
	output sro_pkg::cmd_t  cmd
);
	import sro_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DISP  = 7'b0000010,
		S_DFAR  = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_HBDR  = 7'b0010000,
		S_SDGAP = 7'b0100000,
		S_SDDR  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   fdrain_q, fdrain_d;   // drain belongs to the far-release loop

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		fdrain_d  = fdrain_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				// the held result of the previous transaction goes out as final
				cmd.last = 1'b1;
				if (start) begin
					cmd.load  = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				if (st.stopped) begin
					state_d = S_IDLE;
				end else begin
					case (st.op)
						OP_DATA: begin
							cmd.set_start = 1'b1;
							state_d       = S_DFAR;
						end
						OP_HB: begin
							if (st.hb_idle && st.gap_found) begin
								cmd.emit_gap = 1'b1;
								state_d      = S_HBDR;
							end else begin
								cmd.hb_mark = 1'b1;
								state_d     = S_IDLE;
							end
						end
						OP_SHUT: begin
							cmd.shut_cnt = 1'b1;
							state_d      = st.shut_hit ? S_SDGAP : S_IDLE;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			// release loop for items beyond the window, then final action
			S_DFAR: begin
				if (st.far) begin
					if (st.gap_found) begin
						cmd.emit_gap = 1'b1;
						fdrain_d     = 1'b1;
						state_d      = S_DRAIN;
					end else begin
						cmd.emit_fgap = 1'b1;
						state_d       = S_DFAR;
					end
				end else if (st.eq) begin
					cmd.emit_item = 1'b1;
					fdrain_d      = 1'b0;
					state_d       = S_DRAIN;
				end else begin
					if (st.gt) begin
						cmd.stash = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_DRAIN: begin
				if (st.exp_full) begin
					cmd.emit_slot = 1'b1;
				end else begin
					state_d = fdrain_q ? S_DFAR : S_IDLE;
				end
			end
			// heartbeat mark takes the expected number after the drain
			S_HBDR: begin
				if (st.exp_full) begin
					cmd.emit_slot = 1'b1;
				end else begin
					cmd.hb_mark = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_SDGAP: begin
				if (st.gap_found) begin
					cmd.emit_gap = 1'b1;
					state_d      = S_SDDR;
				end else begin
					cmd.emit_shut = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SDDR: begin
				if (st.exp_full) begin
					cmd.emit_slot = 1'b1;
				end else begin
					state_d = S_SDGAP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fdrain_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			fdrain_q  <= fdrain_d;
		end
	end
endmodule

### design/sequence_reorder_with_gaps.sv
// ----------------------------------------------------------------------------
// sequence_reorder_with_gaps: sequence-number reorder buffer with gap reports
//
//   channel   signals                          direction
//   input     start, busy, in_item             start/busy command
//   result    res_valid, res_item              strobe, one cycle, no stall
//   config    cfg_valid, cfg_ready, cfg_data   valid/ready write
//
// Busy stays high for dispatch, for each result formed and to close each stash
// walk; a plain heartbeat or shutdown holds it for dispatch alone.
// Each result is held until the next is formed; the final one leaves in the first
// idle cycle, so its strobe comes in the cycle after busy drops.
// Reset is asynchronous, active low; the stash valid bits clear at once.
// Results cannot be stalled; busy holds off new items while one is in work.
// ----------------------------------------------------------------------------
module sequence_reorder_with_gaps (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sro_pkg::in_item_t  in_item,
	output logic               res_valid,
	output sro_pkg::out_item_t res_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import sro_pkg::*;

	cmd_t       cmd;
	stat_t      st;
	logic [7:0] need_q;

	assign cfg_ready = 1'b1;

	// shutdown threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			need_q <= cfg_data;
		end
	end

	sro_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.busy   (busy),
		.cmd    (cmd)
	);

	sro_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (in_item),
		.shut_need  (need_q),
		.cmd        (cmd),
		.st         (st),
		.res        (res_item),
		.res_strobe (res_valid)
	);

`ifndef ASSERT_OFF
	// one emit command at most per cycle
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.emit_item, cmd.emit_slot, cmd.emit_gap, cmd.emit_fgap,
			cmd.emit_shut}) <= 1)
		else $error("multiple emits");
	// no result while idle, apart from the final strobe just after busy drops
	a_no_idle_res: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !$past(busy) && !$past(busy, 2)) |-> !res_valid)
		else $error("result while idle");
	// shutdown result is always final
	a_shut_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.kind == KIND_SHUT) |-> res_item.last)
		else $error("shutdown not last");
`endif
endmodule

### tb/sv/tb_sequence_reorder_with_gaps.sv
// ----------------------------------------------------------------------------
// tb_sequence_reorder_with_gaps: self-checking bench for the reorder buffer
// Drives data, heartbeat and shutdown items through the start/busy port,
// predicts every result in-bench and checks each strobed result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sequence_reorder_with_gaps;
	import sro_pkg::*;

	localparam logic [1:0] OP_BAD = 2'd3;  // unused opcode, must be ignored
	localparam int SETTLE_CYC = 120;       // covers the longest drain/release walk

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t in_item;
	logic res_valid;
	out_item_t res_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_data;

	// reorder state mirror
	logic [31:0] next_seq;
	logic [31:0] hb_seq;
	logic [7:0] shut_cnt;
	logic [7:0] shut_need;
	bit halted;
	bit stash_full[WINDOW];
	logic [31:0] stash_word[WINDOW];

	out_item_t pending_q[$];
	int new_res;
	int err_cnt;
	int item_cnt;
	int res_cnt;
	int gap_cnt;
	bit allow_idle;

	sequence_reorder_with_gaps u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.res_valid(res_valid),
		.res_item(res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic void push_res(logic [1:0] kind, logic [31:0] a, logic [31:0] b,
			logic [31:0] pay);
		out_item_t r;
		r.kind = kind;
		r.out_seq = a;
		r.gap_last = b;
		r.out_payload = pay;
		r.last = 1'b0;
		pending_q.push_back(r);
		new_res++;
	endfunction

	// release consecutive stashed items starting at next_seq
	function automatic void drain_stash();
		while (stash_full[next_seq % WINDOW]) begin
			push_res(KIND_DATA, next_seq, 32'd0, stash_word[next_seq % WINDOW]);
			stash_full[next_seq % WINDOW] = 0;
			next_seq = next_seq + 32'd1;
		end
	endfunction

	// report the hole up to the next stashed item, if any
	function automatic bit report_gap();
		logic [31:0] stop_at;
		for (int d = 1; d < WINDOW; d++) begin
			stop_at = next_seq + d;
			if (stash_full[stop_at % WINDOW]) begin
				push_res(KIND_GAP, next_seq, stop_at - 32'd1, 32'd0);
				next_seq = stop_at;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void predict_item(in_item_t it);
		logic [7:0] need;
		new_res = 0;
		if (halted)
			return;
		case (it.op)
			OP_DATA: begin
				if (next_seq == 32'd0)
					next_seq = it.seq;
				while (it.seq > next_seq && it.seq - next_seq >= WINDOW) begin
					if (!report_gap()) begin
						push_res(KIND_GAP, next_seq, it.seq - 32'd1, 32'd0);
						next_seq = it.seq;
						break;
					end
					drain_stash();
				end
				if (it.seq == next_seq) begin
					push_res(KIND_DATA, it.seq, 32'd0, it.payload);
					next_seq = next_seq + 32'd1;
					drain_stash();
				end else if (it.seq > next_seq && !stash_full[it.seq % WINDOW]) begin
					stash_full[it.seq % WINDOW] = 1;
					stash_word[it.seq % WINDOW] = it.payload;
				end
			end
			OP_HB: begin
				if (next_seq == hb_seq && report_gap())
					drain_stash();
				hb_seq = next_seq;
			end
			OP_SHUT: begin
				need = (shut_need == 8'd0) ? 8'd1 : shut_need;
				shut_cnt = shut_cnt + 8'd1;
				if (shut_cnt == need) begin
					while (report_gap())
						drain_stash();
					push_res(KIND_SHUT, 32'd0, 32'd0, 32'd0);
					halted = 1;
				end
			end
			default: ;
		endcase
		if (new_res > 0)
			pending_q[pending_q.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			res_cnt++;
			if (res_item.kind == KIND_GAP)
				gap_cnt++;
			if (pending_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result, expected none, actual %h", $realtime,
					res_item);
			end else begin
				out_item_t e;
				e = pending_q.pop_front();
				if (res_item.kind !== e.kind) begin
					err_cnt++;
					$display("%0t: kind expected %0d actual %0d", $realtime, e.kind,
						res_item.kind);
				end
				if (res_item.out_seq !== e.out_seq) begin
					err_cnt++;
					$display("%0t: out_seq expected %h actual %h", $realtime, e.out_seq,
						res_item.out_seq);
				end
				if (res_item.gap_last !== e.gap_last) begin
					err_cnt++;
					$display("%0t: gap_last expected %h actual %h", $realtime, e.gap_last,
						res_item.gap_last);
				end
				if (res_item.out_payload !== e.out_payload) begin
					err_cnt++;
					$display("%0t: out_payload expected %h actual %h", $realtime,
						e.out_payload, res_item.out_payload);
				end
				if (res_item.last !== e.last) begin
					err_cnt++;
					$display("%0t: last expected %0d actual %0d", $realtime, e.last,
						res_item.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// drivers; all called at a rising edge
	// ------------------------------------------------------------------
	task automatic idle(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// start stays high on return so back-to-back items need no extra edge
	task automatic send_item(logic [1:0] op, logic [31:0] seq, logic [31:0] pay);
		in_item_t it;
		it.op = op;
		it.seq = seq;
		it.payload = pay;
		start <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_item(it);
		item_cnt++;
		if (allow_idle && $urandom_range(0, 4) == 0)
			idle($urandom_range(1, 18));
	endtask

	task automatic send_data(logic [31:0] seq);
		send_item(OP_DATA, seq, $urandom());
	endtask

	// wait until the block has nothing left to do
	task automatic settle();
		idle(1);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_cfg(logic [7:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shut_need = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		// zero acts like one; no shutdown is sent while it is set
		write_cfg(8'd0);
		send_item(OP_DATA, 32'd5, 32'h0000_0000);   // start point
		send_item(OP_DATA, 32'd7, 32'hFFFF_FFFF);   // stashed
		send_item(OP_DATA, 32'd6, 32'hA5A5_5A5A);   // in order, drains 7
		send_item(OP_DATA, 32'd6, 32'h1111_1111);   // old, dropped
		send_item(OP_DATA, 32'd10, 32'h2222_2222);  // stashed
		send_item(OP_DATA, 32'd10, 32'h3333_3333);  // second copy, dropped
		send_item(OP_HB, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // progress since mark
		send_item(OP_HB, 32'd0, 32'd0);             // no progress: skip 8..9
		send_item(OP_DATA, 32'd13, 32'h4444_4444);  // stashed
		send_item(OP_DATA, 32'd50, 32'h5555_5555);  // far: release then gap
		send_item(OP_BAD, 32'd51, 32'h6666_6666);   // ignored
		send_item(OP_DATA, 32'd51, 32'h7777_7777);
		write_cfg(8'd255);
		send_item(OP_SHUT, 32'd0, 32'd0);           // counted only
		// fill the stash, then jump far: longest release
		for (int i = 2; i <= 16; i++)
			send_data(32'd51 + i);
		send_item(OP_DATA, 32'h8000_0000, 32'hFFFF_FFFF);
		// wrap of the sequence space restarts the start point
		send_item(OP_DATA, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
		send_item(OP_DATA, 32'd0, 32'hF0F0_0F0F);
		send_item(OP_DATA, 32'd1, 32'h1234_5678);
	endtask

	task automatic test_random(int n_items);
		logic [31:0] seqs[$];
		int n;
		int j;
		logic [31:0] t;
		allow_idle = 1;
		while (item_cnt < n_items) begin
			if (item_cnt > n_items / 2 && item_cnt < n_items / 2 + 15)
				settle();   // hold off until the block is drained
			case ($urandom_range(0, 19))
				0, 1: send_item(OP_HB, $urandom(), $urandom());
				2: begin
					if (shut_cnt < 8'd200)
						send_item(OP_SHUT, $urandom(), $urandom());
				end
				3: send_item(OP_BAD, $urandom(), $urandom());
				4: send_data($urandom());
				5: send_data(next_seq + $urandom_range(16, 60));
				6: send_data(next_seq - $urandom_range(1, 8));
				default: begin
					// a shuffled run of consecutive numbers, sometimes with a hole
					n = $urandom_range(2, 14);
					seqs.delete();
					for (int i = 0; i < n; i++)
						seqs.push_back(next_seq + i);
					if ($urandom_range(0, 3) == 0)
						seqs.delete($urandom_range(0, n - 1));
					for (int i = seqs.size() - 1; i > 0; i--) begin
						j = $urandom_range(0, i);
						t = seqs[i];
						seqs[i] = seqs[j];
						seqs[j] = t;
					end
					foreach (seqs[i])
						send_data(seqs[i]);
				end
			endcase
		end
		allow_idle = 0;
	endtask

	task automatic test_shutdown();
		write_cfg(shut_cnt + 8'd1);
		// leave holes in the stash so the flush has gaps to report
		send_data(next_seq + 3);
		send_data(next_seq + 7);
		send_data(next_seq + 12);
		send_item(OP_SHUT, 32'd0, 32'd0);
		// after the forwarded shutdown everything is ignored
		send_data(next_seq);
		send_item(OP_HB, 32'd0, 32'd0);
		send_item(OP_SHUT, 32'd0, 32'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = 8'd0;
		next_seq = 32'd0;
		hb_seq = 32'd0;
		shut_cnt = 8'd0;
		shut_need = 8'd1;
		halted = 0;
		foreach (stash_full[i])
			stash_full[i] = 0;
		err_cnt = 0;
		item_cnt = 0;
		res_cnt = 0;
		gap_cnt = 0;
		allow_idle = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(180);
		test_shutdown();
		settle();

		$display("Sent %0d items (data, heartbeat, shutdown, unknown op); checked %0d results",
			item_cnt, res_cnt);
		$display("including %0d gap reports, across shutdown limits 0, 255 and a final count",
			gap_cnt);
		if (err_cnt == 0)
			$display("tb_sequence_reorder_with_gaps: PASS");
		else
			$display("tb_sequence_reorder_with_gaps: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb_sequence_reorder_with_gaps: FAIL");
		$finish;
	end
endmodule
